[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the deque core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define DQ_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication checked on the next edge, held off while reset is asserted
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// shared constants, codes and control types of the deque core
// ----------------------------------------------------------------------------
package dq_pkg;

    // storage geometry
    localparam int DEPTH   = 128;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 8;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // command to a whole chain
    typedef struct packed {
        logic  ins_head;
        logic  del_head;
        logic  wr_tail;
        cnt_t  tail_pos;
        word_t value;
    } chain_cmd_t;

    // command to one cell
    typedef struct packed {
        logic  ins_head;
        logic  del_head;
        logic  wr_en;
        word_t value;
    } cell_cmd_t;

endpackage

[rtl/core/bounded_deque_with_error_checks_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_error_checks_core
// bounded double-ended queue of signed words with empty and full status
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_kind s_push_value          | in
//  result  | m_valid m_ready m_status m_pop_value         | out
//          | m_front_value m_back_value m_count           |
//
//  one beat in, one result beat out, one beat per cycle; the result sits
//  in an output register, so a new beat is taken while the last result
//  waits as long as it is taken in the same cycle.
//  two cell chains hold the words, one ordered from the front and one from
//  the back, so both ends are read at fixed cells.
//  synchronous active-low reset empties the deque; cell contents keep.
//  a stalled result holds s_ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_error_checks_core import dq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic        [KIND_W-1:0] s_kind,
    input  logic signed [DATA_W-1:0] s_push_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic        [STAT_W-1:0] m_status,
    output logic signed [DATA_W-1:0] m_pop_value,
    output logic signed [DATA_W-1:0] m_front_value,
    output logic signed [DATA_W-1:0] m_back_value,
    output logic       [COUNT_W-1:0] m_count
);

    cnt_t                count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic   [STAT_W-1:0] status_reg, status_next;
    word_t               pop_reg, pop_next;
    word_t               front_reg, front_next;
    word_t               back_reg, back_next;
    cnt_t                cnt_out_reg;

    chain_cmd_t f_cmd, b_cmd;
    word_t      f_head, f_second, b_head, b_second;
    word_t      f_head_next, b_head_next;
    logic       s_fire, is_empty, is_full;
    logic       one_held, empty_out, first_push, ends_match;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // operation decode
    always_comb begin
        f_cmd          = '0;
        b_cmd          = '0;
        f_cmd.value    = s_push_value;
        b_cmd.value    = s_push_value;
        f_cmd.tail_pos = count_reg;
        b_cmd.tail_pos = count_reg;
        count_next     = count_reg;
        status_next    = ST_OK;
        pop_next       = '0;
        f_head_next    = f_head;
        b_head_next    = b_head;
        case (s_kind)
            KIND_PUSH_HEAD: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    f_cmd.ins_head = 1'b1;
                    b_cmd.wr_tail  = 1'b1;
                    count_next     = count_reg + 1'b1;
                    f_head_next    = s_push_value;
                    if (is_empty) begin
                        b_head_next = s_push_value;
                    end
                end
            end
            KIND_PUSH_TAIL: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    b_cmd.ins_head = 1'b1;
                    f_cmd.wr_tail  = 1'b1;
                    count_next     = count_reg + 1'b1;
                    b_head_next    = s_push_value;
                    if (is_empty) begin
                        f_head_next = s_push_value;
                    end
                end
            end
            KIND_POP_HEAD: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    f_cmd.del_head = 1'b1;
                    pop_next       = f_head;
                    count_next     = count_reg - 1'b1;
                    f_head_next    = f_second;
                end
            end
            KIND_POP_TAIL: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    b_cmd.del_head = 1'b1;
                    pop_next       = b_head;
                    count_next     = count_reg - 1'b1;
                    b_head_next    = b_second;
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            KIND_PEEK: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
        // nothing moves without a beat
        if (!s_fire) begin
            f_cmd.ins_head = 1'b0;
            f_cmd.del_head = 1'b0;
            f_cmd.wr_tail  = 1'b0;
            b_cmd.ins_head = 1'b0;
            b_cmd.del_head = 1'b0;
            b_cmd.wr_tail  = 1'b0;
            count_next     = count_reg;
        end
    end

    // end words after the step, zero when empty
    always_comb begin
        front_next = (count_next == '0) ? '0 : f_head_next;
        back_next  = (count_next == '0) ? '0 : b_head_next;
    end

    // chain ordered from the front
    dq_chain u_front_chain (
        .aclk   (aclk),
        .cmd    (f_cmd),
        .head   (f_head),
        .second (f_second)
    );

    // chain ordered from the back
    dq_chain u_back_chain (
        .aclk   (aclk),
        .cmd    (b_cmd),
        .head   (b_head),
        .second (b_second)
    );

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg  <= status_next;
            pop_reg     <= pop_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            cnt_out_reg <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_pop_value   = pop_reg;
    assign m_front_value = front_reg;
    assign m_back_value  = back_reg;
    assign m_count       = COUNT_W'(cnt_out_reg);

    // terms for the checks
    assign one_held   = (count_reg == CNT_W'(1));
    assign empty_out  = m_valid && (m_status == ST_EMPTY);
    assign first_push = s_fire && is_empty
                        && ((s_kind == KIND_PUSH_TAIL) || (s_kind == KIND_PUSH_HEAD));
    assign ends_match = (m_front_value == m_back_value) && (m_count == COUNT_W'(1));

    // checks
    `DQ_ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(DEPTH), "count beyond depth")
    `DQ_ASSERT_CLK(a_single_heads, one_held |-> (f_head == b_head), "chains disagree")
    `DQ_ASSERT_CLK(a_empty_status, empty_out |-> (m_count == '0), "empty with words held")
    `DQ_ASSERT_NEXT(a_first_push, first_push, ends_match, "first push ends differ")

endmodule

[rtl/core/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell
// one storage cell of a shifting chain: holds, takes a neighbour or loads
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  word_t     prev_data,
    input  word_t     next_data,
    output word_t     data
);

    word_t data_reg;
    word_t data_next;

    // insert moves towards the tail, delete moves towards the head
    always_comb begin
        data_next = data_reg;
        if (cmd.ins_head) begin
            data_next = prev_data;
        end else if (cmd.del_head) begin
            data_next = next_data;
        end else if (cmd.wr_en) begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/dq_chain.sv]
// ----------------------------------------------------------------------------
// dq_chain
// row of cells holding the deque in order from one end
// ----------------------------------------------------------------------------
module dq_chain import dq_pkg::*; (
    input  logic       aclk,
    input  chain_cmd_t cmd,
    output word_t      head,
    output word_t      second
);

    word_t cell_data [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            cell_cmd_t ccmd;
            word_t     prev_d;
            word_t     next_d;

            // per-cell decode of the tail write position
            always_comb begin
                ccmd.ins_head = cmd.ins_head;
                ccmd.del_head = cmd.del_head;
                ccmd.wr_en    = cmd.wr_tail && (cmd.tail_pos == CNT_W'(gi));
                ccmd.value    = cmd.value;
            end

            // neighbour links, the ends take the new word or hold
            if (gi == 0) begin : g_first
                assign prev_d = cmd.value;
            end else begin : g_mid_prev
                assign prev_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_d = cell_data[gi];
            end else begin : g_mid_next
                assign next_d = cell_data[gi+1];
            end

            dq_cell u_cell (
                .aclk      (aclk),
                .cmd       (ccmd),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign head   = cell_data[0];
    assign second = cell_data[1];

endmodule
